/* hw/rtl/hash_table_depth_age_replace_core_macros.svh */
// Assertion macros for the hash table core.
// Used by htdar_back; expects i_clk and i_rst_n in scope.
`ifndef HASH_TABLE_DEPTH_AGE_REPLACE_CORE_MACROS_SVH
`define HASH_TABLE_DEPTH_AGE_REPLACE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HTDAR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("htdar check failed");
`define HTDAR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("htdar check failed");
`else
`define HTDAR_ASSERT(lbl, cond)
`define HTDAR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/htdar_pkg.sv */
// Types and codes shared by the hash table core.
// No dependencies.
package htdar_pkg;

    localparam logic [2:0] OP_PROBE  = 3'd0;
    localparam logic [2:0] OP_STORE  = 3'd1;
    localparam logic [2:0] OP_SEVAL  = 3'd2;
    localparam logic [2:0] OP_NEWS   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // work classes handed from front to back
    localparam logic [2:0] K_NOP   = 3'd0;
    localparam logic [2:0] K_PROBE = 3'd1;
    localparam logic [2:0] K_STORE = 3'd2;
    localparam logic [2:0] K_SEVAL = 3'd3;
    localparam logic [2:0] K_NEWS  = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;

    localparam logic CFG_EXACT  = 1'b0;
    localparam logic CFG_NOMOVE = 1'b1;
    localparam int   CFG_W      = 17;

    typedef struct packed {
        logic [2:0]         op;
        logic [63:0]        key;
        logic signed [7:0]  search_depth;
        logic signed [15:0] score;
        logic [1:0]         bound_flag;
        logic [16:0]        best_move;
        logic signed [15:0] eval_value;
        logic               eval_valid;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] found_score;
        logic signed [15:0] found_eval;
        logic [16:0]        found_move;
        logic signed [7:0]  found_depth;
        logic [1:0]         found_flag;
        logic               found_eval_valid;
        logic [7:0]         found_age;
    } t_out;

    typedef struct packed {
        logic [2:0] kind;
        t_in        item;
    } t_cmd;

    typedef struct packed {
        logic               eval_set;
        logic [1:0]         flag;
        logic signed [7:0]  depth;
        logic [16:0]        move;
        logic signed [15:0] eval;
        logic signed [15:0] score;
    } t_payload;

    function automatic logic signed [7:0] clamp_depth(input logic signed [7:0] d);
        clamp_depth = (d < -8'sd1) ? -8'sd1 : d;
    endfunction

endpackage

/* hw/rtl/htdar_front.sv */
// Front end: accepts beats, classifies them, two-entry command queue.
// Depends on htdar_pkg.
module htdar_front import htdar_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    input  logic i_block,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cmd;
    logic       push;
    logic       key_nz;

    always_comb begin
        key_nz   = i_data.key != 64'd0;
        cmd.item = i_data;
        case (i_data.op)
            OP_PROBE: cmd.kind = key_nz ? K_PROBE : K_NOP;
            OP_STORE: cmd.kind = key_nz ? K_STORE : K_NOP;
            OP_SEVAL: cmd.kind = key_nz ? K_SEVAL : K_NOP;
            OP_NEWS:  cmd.kind = K_NEWS;
            OP_CLEAR: cmd.kind = K_CLEAR;
            default:  cmd.kind = K_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2) && !i_block;
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

/* hw/rtl/htdar_back.sv */
// Back end: bucket memory, lookup/replace sequencer, result register.
// Depends on htdar_pkg and the core assertion macros.
`include "hash_table_depth_age_replace_core_macros.svh"
module htdar_back import htdar_pkg::*; #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_init,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int TAG_W = 64 - IDX_W;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [7:0]       age;
        t_payload         pay;
    } t_slot;
    typedef t_slot [WAYS-1:0] t_row;

    t_row r_mem [BUCKETS];
    t_row r_rd_row;

    logic [2:0]       r_state, n_state;
    logic [7:0]       r_gen, n_gen;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic             r_clr_res, n_clr_res;
    logic             r_init, n_init;
    t_cmd             r_cmd, n_cmd;
    t_out             r_res, n_res;
    logic             r_o_valid, n_o_valid;
    t_out             r_o_data, n_o_data;
    logic             r_hit, n_hit, r_ehit, n_ehit;
    logic [WAY_W-1:0] r_mw, n_mw, r_ew, n_ew, r_vw, n_vw;
    logic [1:0]       r_exact;
    logic [16:0]      r_nomove;

    logic [IDX_W-1:0] rd_addr, w_addr;
    logic             w_en;
    t_row             w_row;
    logic [TAG_W-1:0] cmd_tag;
    t_slot            s_old, s_new;
    t_payload         p;
    logic             upd, wr_slot;
    logic [WAY_W-1:0] w_way;
    logic             c_old, v_old;

    assign cmd_tag = r_cmd.item.key[63:IDX_W];
    assign rd_addr = (r_state == S_IDLE) ? i_cmd.item.key[IDX_W-1:0]
                                         : r_cmd.item.key[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_mem[rd_addr];
        if (w_en) begin
            r_mem[w_addr] <= w_row;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_gen     = r_gen;
        n_clr_idx = r_clr_idx;
        n_clr_res = r_clr_res;
        n_init    = r_init;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_o_valid = r_o_valid && !i_ready;
        n_o_data  = r_o_data;
        n_hit     = r_hit;
        n_ehit    = r_ehit;
        n_mw      = r_mw;
        n_ew      = r_ew;
        n_vw      = r_vw;
        o_cmd_pop = 1'b0;
        w_en      = 1'b0;
        w_addr    = r_cmd.item.key[IDX_W-1:0];
        w_row     = r_rd_row;
        s_old     = r_rd_row[r_mw];
        s_new     = s_old;
        p         = s_old.pay;
        upd       = 1'b0;
        wr_slot   = 1'b0;
        w_way     = r_mw;
        c_old     = 1'b0;
        v_old     = 1'b0;

        case (r_state)
            S_CLR: begin
                w_en      = 1'b1;
                w_addr    = r_clr_idx;
                w_row     = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == {IDX_W{1'b1}}) begin
                    n_init  = 1'b0;
                    n_res   = '0;
                    n_state = r_clr_res ? S_RES : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_res     = '0;
                    case (i_cmd.kind)
                        K_PROBE, K_STORE, K_SEVAL: n_state = S_RD;
                        K_NEWS: begin
                            n_gen   = r_gen + 8'd1;
                            n_state = S_RES;
                        end
                        K_CLEAR: begin
                            n_gen     = 8'd0;
                            n_clr_idx = '0;
                            n_clr_res = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end
            S_RD: begin
                // first match, first empty, and replacement victim
                n_hit  = 1'b0;
                n_ehit = 1'b0;
                n_mw   = '0;
                n_ew   = '0;
                n_vw   = '0;
                for (int w = 0; w < WAYS; w++) begin
                    if (!n_hit && r_rd_row[w].valid && r_rd_row[w].tag == cmd_tag) begin
                        n_hit = 1'b1;
                        n_mw  = WAY_W'(w);
                    end
                    if (!n_ehit && !r_rd_row[w].valid) begin
                        n_ehit = 1'b1;
                        n_ew   = WAY_W'(w);
                    end
                end
                for (int w = 1; w < WAYS; w++) begin
                    c_old = r_rd_row[w].age != r_gen;
                    v_old = r_rd_row[n_vw].age != r_gen;
                    if ((c_old && !v_old) || (c_old == v_old &&
                        r_rd_row[w].pay.depth < r_rd_row[n_vw].pay.depth)) begin
                        n_vw = WAY_W'(w);
                    end
                end
                n_state = S_WR;
            end
            S_WR: begin
                n_state = S_RES;
                case (r_cmd.kind)
                    K_PROBE: begin
                        if (r_hit) begin
                            n_res.hit              = 1'b1;
                            n_res.found_score      = s_old.pay.score;
                            n_res.found_eval       = s_old.pay.eval;
                            n_res.found_move       = s_old.pay.move;
                            n_res.found_depth      = s_old.pay.depth;
                            n_res.found_flag       = s_old.pay.flag;
                            n_res.found_eval_valid = s_old.pay.eval_set;
                            n_res.found_age        = s_old.age;
                        end
                    end
                    K_STORE: begin
                        wr_slot = 1'b1;
                        if (r_hit) begin
                            if (r_cmd.item.search_depth >= s_old.pay.depth ||
                                r_cmd.item.bound_flag == r_exact) begin
                                p.depth = clamp_depth(r_cmd.item.search_depth);
                                p.score = r_cmd.item.score;
                                p.flag  = r_cmd.item.bound_flag;
                                if (r_cmd.item.best_move != r_nomove) begin
                                    p.move = r_cmd.item.best_move;
                                end
                                if (r_cmd.item.eval_valid) begin
                                    p.eval     = r_cmd.item.eval_value;
                                    p.eval_set = 1'b1;
                                end
                                upd = 1'b1;
                            end else if (r_cmd.item.best_move != r_nomove &&
                                         s_old.pay.move == r_nomove) begin
                                p.move = r_cmd.item.best_move;
                                if (r_cmd.item.eval_valid) begin
                                    p.eval     = r_cmd.item.eval_value;
                                    p.eval_set = 1'b1;
                                end
                                upd = 1'b1;
                            end else if (r_cmd.item.eval_valid && !s_old.pay.eval_set) begin
                                p.eval     = r_cmd.item.eval_value;
                                p.eval_set = 1'b1;
                                upd        = 1'b1;
                            end
                            s_new.pay = p;
                            if (upd) begin
                                s_new.age = r_gen;
                            end
                        end else begin
                            w_way              = r_ehit ? r_ew : r_vw;
                            s_new.valid        = 1'b1;
                            s_new.tag          = cmd_tag;
                            s_new.age          = r_gen;
                            s_new.pay.eval_set = r_cmd.item.eval_valid;
                            s_new.pay.flag     = r_cmd.item.bound_flag;
                            s_new.pay.depth    = clamp_depth(r_cmd.item.search_depth);
                            s_new.pay.move     = r_cmd.item.best_move;
                            s_new.pay.eval     = r_cmd.item.eval_valid ?
                                                 r_cmd.item.eval_value : 16'sd0;
                            s_new.pay.score    = r_cmd.item.score;
                        end
                    end
                    K_SEVAL: begin
                        if (r_hit) begin
                            wr_slot            = 1'b1;
                            s_new.pay.eval     = r_cmd.item.eval_value;
                            s_new.pay.eval_set = 1'b1;
                            s_new.age          = r_gen;
                        end else if (r_ehit) begin
                            wr_slot            = 1'b1;
                            w_way              = r_ew;
                            s_new.valid        = 1'b1;
                            s_new.tag          = cmd_tag;
                            s_new.age          = r_gen;
                            s_new.pay.eval_set = 1'b1;
                            s_new.pay.flag     = r_exact;
                            s_new.pay.depth    = -8'sd1;
                            s_new.pay.move     = r_nomove;
                            s_new.pay.eval     = r_cmd.item.eval_value;
                            s_new.pay.score    = 16'sd0;
                        end
                    end
                    default: ;
                endcase
                if (wr_slot) begin
                    w_en         = 1'b1;
                    w_row[w_way] = s_new;
                end
            end
            S_RES: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = r_res;
                    n_clr_res = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_gen     <= 8'd0;
            r_clr_idx <= '0;
            r_clr_res <= 1'b0;
            r_init    <= 1'b1;
            r_o_valid <= 1'b0;
            r_exact   <= 2'd1;
            r_nomove  <= 17'd0;
        end else begin
            r_state   <= n_state;
            r_gen     <= n_gen;
            r_clr_idx <= n_clr_idx;
            r_clr_res <= n_clr_res;
            r_init    <= n_init;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXACT:  r_exact  <= i_cfg_wdata[1:0];
                    CFG_NOMOVE: r_nomove <= i_cfg_wdata[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_res    <= n_res;
        r_o_data <= n_o_data;
        r_hit    <= n_hit;
        r_ehit   <= n_ehit;
        r_mw     <= n_mw;
        r_ew     <= n_ew;
        r_vw     <= n_vw;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_init  = r_init;

    `HTDAR_ASSERT(a_no_pop_busy, !(o_cmd_pop && r_state != S_IDLE))
    `HTDAR_ASSERT(a_wr_state, !(w_en && r_state != S_WR && r_state != S_CLR))
    `HTDAR_ASSERT_NEXT(a_gen_step, r_state == S_IDLE && o_cmd_pop && i_cmd.kind == K_NEWS,
        r_gen == $past(r_gen) + 8'd1)
    `HTDAR_ASSERT(a_hit_probe, !(r_state == S_RES && r_res.hit && r_cmd.kind != K_PROBE))

endmodule

/* hw/rtl/hash_table_depth_age_replace_core.sv */
// Top level of the depth/age-replacement hash table core.
// Depends on htdar_pkg, htdar_front and htdar_back.
//
// Input channel i_valid/o_ready carries one operation beat (probe, store,
// store eval, new search, clear); output channel o_valid/i_ready returns
// exactly one result beat per operation, in order. Config registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_wdata with no handshake.
// A probe or store goes from the queue hand-off with bucket read through way
// compare and write-back to the result register. The back end sequencer
// takes one operation at a time and finishes it before it pops the next.
// New search and no-op beats skip the bucket read, compare and write-back.
// Clear sweeps one bucket per cycle.
// After reset a clearing pass over every bucket runs with o_ready low.
// A two-beat queue keeps taking beats while the back end is busy, and the
// result register holds a beat while i_ready is low; the back end stalls
// until it is taken.
module hash_table_depth_age_replace_core import htdar_pkg::*; #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic cmd_valid, cmd_pop, init;
    t_cmd cmd;

    htdar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_block     (init),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    htdar_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init      (init),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
